>>> hw/rtl/tepq_pkg.sv
package tepq_pkg;

   // action codes on the request word
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // status codes on the response word
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int TIME_W = 32;
   localparam int OBJ_W  = 16;
   localparam int HND_W  = 8;
   localparam int OCC_W  = 7;

   typedef struct packed {
      logic [TIME_W-1:0] event_time;
      logic [OBJ_W-1:0]  object_tag;
      logic [HND_W-1:0]  handler_tag;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic pop;
   } cell_ctl_type;

endpackage

>>> hw/rtl/tepq_if.sv
interface tepq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] event_time;
   logic [15:0] object_tag;
   logic [7:0]  handler_tag;

   modport source (output valid, action, event_time, object_tag, handler_tag,
                   input ready);
   modport sink   (input valid, action, event_time, object_tag, handler_tag,
                   output ready);
endinterface

interface tepq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] popped_time;
   logic [15:0] popped_object;
   logic [7:0]  popped_handler;
   logic [6:0]  occupancy;

   modport source (output valid, status, popped_time, popped_object, popped_handler,
                   occupancy, input ready);
   modport sink   (input valid, status, popped_time, popped_object, popped_handler,
                   occupancy, output ready);
endinterface

>>> hw/rtl/tepq_cell.sv
module tepq_cell (
   input  logic                       clock,
   input  tepq_pkg::cell_ctl_type     ctl,
   input  logic                       occ,
   input  logic [tepq_pkg::TIME_W-1:0] key,
   input  tepq_pkg::entry_type        new_data,
   input  tepq_pkg::entry_type        left_data,
   input  logic                       left_gt,
   input  tepq_pkg::entry_type        right_data,
   output tepq_pkg::entry_type        data,
   output logic                       gt
);

   tepq_pkg::entry_type data_ff, data_in;

   // empty slots count as later than any key, so the insert point is the
   // first cell that reports gt
   assign gt   = !occ || (data_ff.event_time > key);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins && gt) begin
         data_in = left_gt ? left_data : new_data;
      end else if (ctl.pop) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> hw/rtl/timed_event_priority_queue_core.sv
// Flow: the accepted word sits in the command register until the response
//   slot is free, and is applied at the edge that loads the response word.
// Accept: a new word is taken only once the held word has been applied.
// Reset: synchronous, clears the fill count and the handshake flags; the
//   cell contents are left as they are and never read while unoccupied.
module timed_event_priority_queue_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   tepq_req_if.sink    req_ch,
   tepq_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // command register: holds the accepted word until it is applied
   logic                busy_ff, busy_in;
   logic [1:0]          act_ff, act_in;
   tepq_pkg::entry_type cmd_ff, cmd_in;

   // fill count: cells below it are occupied, earliest at cell 0
   logic [CNT_W-1:0]    count_ff, count_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff, status_in;
   tepq_pkg::entry_type popped_ff, popped_in;

   logic                  exec;
   logic                  is_full, is_empty;
   tepq_pkg::cell_ctl_type ctl;

   tepq_pkg::entry_type cell_data [QUEUE_DEPTH];
   logic                cell_gt   [QUEUE_DEPTH];

   assign req_ch.ready = !busy_ff;

   // apply the held command once the response slot is free
   assign exec     = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctl.ins = exec && (act_ff == tepq_pkg::ACT_INSERT) && !is_full;
   assign ctl.pop = exec && (act_ff == tepq_pkg::ACT_POP) && !is_empty;

   // chain of cells; insert shifts right from the insert point on a
   // parallel compare, pop shifts everything left by one
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tepq_pkg::entry_type left_data, right_data;
      logic                left_gt;

      if (i == 0) begin : g_head
         assign left_data = cmd_ff;
         assign left_gt   = 1'b0;
      end else begin : g_body
         assign left_data = cell_data[i-1];
         assign left_gt   = cell_gt[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_mid
         assign right_data = cell_data[i+1];
      end

      tepq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occ        (CNT_W'(i) < count_ff),
         .key        (cmd_ff.event_time),
         .new_data   (cmd_ff),
         .left_data  (left_data),
         .left_gt    (left_gt),
         .right_data (right_data),
         .data       (cell_data[i]),
         .gt         (cell_gt[i])
      );
   end

   always_comb begin
      busy_in      = busy_ff;
      act_in       = act_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_ch.valid && !busy_ff) begin
         busy_in                = 1'b1;
         act_in                 = req_ch.action;
         cmd_in.event_time      = req_ch.event_time;
         cmd_in.object_tag      = req_ch.object_tag;
         cmd_in.handler_tag     = req_ch.handler_tag;
      end

      if (exec) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         status_in    = tepq_pkg::ST_OK;
         popped_in    = '0;
         case (act_ff)
            tepq_pkg::ACT_INSERT: begin
               if (is_full) begin
                  status_in = tepq_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            tepq_pkg::ACT_POP: begin
               if (is_empty) begin
                  status_in = tepq_pkg::ST_EMPTY;
               end else begin
                  popped_in = cell_data[0];
                  count_in  = count_ff - 1'b1;
               end
            end
            tepq_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // unused code: no change, plain ok word
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff    <= act_in;
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.popped_time    = popped_ff.event_time;
   assign rsp_ch.popped_object  = popped_ff.object_tag;
   assign rsp_ch.popped_handler = popped_ff.handler_tag;

   // occupancy reports the count modulo 128
   if (CNT_W >= tepq_pkg::OCC_W) begin : g_occ_trunc
      assign rsp_ch.occupancy = count_ff[tepq_pkg::OCC_W-1:0];
   end else begin : g_occ_ext
      assign rsp_ch.occupancy = {{(tepq_pkg::OCC_W-CNT_W){1'b0}}, count_ff};
   end

endmodule

>>> hw/rtl/tepq_checker.sv
module tepq_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_popped_time,
   input logic [6:0]  rsp_occupancy
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_occupancy))
      else $error("response word changed while stalled");

   // one word in flight: no accept on the edge after an accept
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word pending");

   // empty pop leaves an empty queue and no popped data
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tepq_pkg::ST_EMPTY |->
         rsp_occupancy == 7'd0 && rsp_popped_time == 32'd0)
      else $error("empty status with nonzero occupancy or data");

   // unused status code never shows
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= tepq_pkg::ST_FULL)
      else $error("undefined status code");

   // nothing pending right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("handshake not idle after reset");

endmodule

bind timed_event_priority_queue_core tepq_props u_tepq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_popped_time (rsp_ch.popped_time),
   .rsp_occupancy   (rsp_ch.occupancy)
);

>>> bench/tepq_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps a sorted shadow of the queue and checks
// every response word against the oldest outstanding prediction.
module tepq_checker #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   tepq_req_if  req_mon,
   tepq_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked,
   output int   popped,
   output int   empty_hits,
   output int   full_hits,
   output int   peak_fill
);

   typedef struct packed {
      logic [1:0]                  status;
      logic [tepq_pkg::TIME_W-1:0] popped_time;
      logic [tepq_pkg::OBJ_W-1:0]  popped_object;
      logic [tepq_pkg::HND_W-1:0]  popped_handler;
      logic [tepq_pkg::OCC_W-1:0]  occupancy;
   } outcome_type;

   tepq_pkg::entry_type held [QUEUE_DEPTH];
   int unsigned fill;
   outcome_type outcome_q [$];
   int          fails, words_seen, pops_ok, pops_empty, drops, fill_max;

   initial begin
      fill = 0;
      fails = 0;
      words_seen = 0;
      pops_ok = 0;
      pops_empty = 0;
      drops = 0;
      fill_max = 0;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH response %0d, %s: got 0x%0h, want 0x%0h",
               words_seen, field, got, want);
      fails++;
   endtask

   // Applies one request word to the shadow queue and returns its response.
   function automatic outcome_type schedule_step(input logic [1:0] act,
                                                 input tepq_pkg::entry_type ev);
      outcome_type res;
      int unsigned pos;
      res = '0;
      res.status = tepq_pkg::ST_OK;
      case (act)
         tepq_pkg::ACT_INSERT: begin
            if (fill >= QUEUE_DEPTH) begin
               res.status = tepq_pkg::ST_FULL;
               drops++;
            end else begin
               // land behind every entry with time <= ours, so ties stay FIFO
               pos = 0;
               while (pos < fill && held[pos].event_time <= ev.event_time) pos++;
               for (int i = fill; i > pos; i--) held[i] = held[i-1];
               held[pos] = ev;
               fill++;
            end
         end
         tepq_pkg::ACT_POP: begin
            if (fill == 0) begin
               res.status = tepq_pkg::ST_EMPTY;
               pops_empty++;
            end else begin
               res.popped_time    = held[0].event_time;
               res.popped_object  = held[0].object_tag;
               res.popped_handler = held[0].handler_tag;
               for (int i = 1; i < fill; i++) held[i-1] = held[i];
               fill--;
               pops_ok++;
            end
         end
         tepq_pkg::ACT_CLEAR: fill = 0;
         default: ;
      endcase
      if (fill > fill_max) fill_max = fill;
      res.occupancy = tepq_pkg::OCC_W'(fill);
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type         want;
      tepq_pkg::entry_type ev;
      if (reset) begin
         fill = 0;
         outcome_q.delete();
      end else begin
         // response first: it always belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            words_seen++;
            if (outcome_q.size() == 0) begin
               report_mismatch("response with nothing outstanding", rsp_mon.status, 0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.popped_time !== want.popped_time)
                  report_mismatch("popped_time", rsp_mon.popped_time, want.popped_time);
               if (rsp_mon.popped_object !== want.popped_object)
                  report_mismatch("popped_object", rsp_mon.popped_object,
                                  want.popped_object);
               if (rsp_mon.popped_handler !== want.popped_handler)
                  report_mismatch("popped_handler", rsp_mon.popped_handler,
                                  want.popped_handler);
               if (rsp_mon.occupancy !== want.occupancy)
                  report_mismatch("occupancy", rsp_mon.occupancy, want.occupancy);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            ev.event_time  = req_mon.event_time;
            ev.object_tag  = req_mon.object_tag;
            ev.handler_tag = req_mon.handler_tag;
            outcome_q.push_back(schedule_step(req_mon.action, ev));
         end
      end
      fail_count <= fails;
      pending    <= outcome_q.size();
      checked    <= words_seen;
      popped     <= pops_ok;
      empty_hits <= pops_empty;
      full_hits  <= drops;
      peak_fill  <= fill_max;
   end

endmodule

>>> bench/timed_event_priority_queue_core_tb.sv
`timescale 1ns / 100ps

module timed_event_priority_queue_core_tb;

   localparam int QUEUE_DEPTH  = 64;
   localparam int MAX_IDLE     = 18;     // longest gap / stall per word
   localparam int RANDOM_WORDS = 1150;
   localparam int STALL_LIMIT  = 2000;   // cycles with no word moving
   localparam int DRAIN_CYCLES = 16;     // tail after the last response

   // action code 3 is unused by the block; it must act as a no-op
   localparam logic [1:0] ACT_SPARE = 2'd3;

   logic clock;
   logic reset;

   tepq_req_if req_ch ();
   tepq_rsp_if rsp_ch ();

   int fail_count, pending, checked, popped, empty_hits, full_hits, peak_fill;
   int sent = 0;
   int quiet_cycles = 0;
   bit no_idle = 1'b0;   // when set, neither side inserts gaps

   timed_event_priority_queue_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   tepq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .fail_count(fail_count),
      .pending(pending),
      .checked(checked),
      .popped(popped),
      .empty_hits(empty_hits),
      .full_hits(full_hits),
      .peak_fill(peak_fill)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any accepted word on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Event times: small keys give lots of ties, plus full range and the edges.
   function automatic logic [31:0] pick_time();
      logic [31:0] key;
      case ($urandom_range(0, 3))
         0: key = $urandom_range(0, 15);
         1: key = $urandom;
         2: begin
            case ($urandom_range(0, 4))
               0:       key = 32'h0000_0000;
               1:       key = 32'hFFFF_FFFF;
               2:       key = 32'h0000_0001;
               3:       key = 32'hFFFF_FFFE;
               default: key = 32'h8000_0000;
            endcase
         end
         default: key = 32'h8000_0000 + $urandom_range(0, 8) - 4;
      endcase
      return key;
   endfunction

   // Drive one request word and hold it until the block takes it. Valid is
   // only dropped when a gap is drawn, so back-to-back words keep it high.
   task automatic send_word(input logic [1:0] act, input logic [31:0] key,
                            input logic [15:0] obj, input logic [7:0] hnd);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.event_time  <= key;
      req_ch.object_tag  <= obj;
      req_ch.handler_tag <= hnd;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic send_insert();
      send_word(tepq_pkg::ACT_INSERT, pick_time(), 16'($urandom), 8'($urandom));
   endtask

   // Non-insert words carry random payload that the block must ignore.
   task automatic send_cmd(input logic [1:0] act);
      send_word(act, $urandom, 16'($urandom), 8'($urandom));
   endtask

   // Mixed traffic; ins_pct sets how hard the queue is pushed toward full.
   task automatic send_mixed(input int ins_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2)                 send_cmd(tepq_pkg::ACT_CLEAR);
      else if (r < 5)            send_cmd(ACT_SPARE);
      else if (r < 5 + ins_pct)  send_insert();
      else                       send_cmd(tepq_pkg::ACT_POP);
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Response side: either ready ahead of valid, or a drawn stall after
   // valid rises.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            do @(posedge clock); while (!rsp_ch.valid);
            repeat (stall - 1) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int directed_words;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= tepq_pkg::ACT_INSERT;
      req_ch.event_time  <= '0;
      req_ch.object_tag  <= '0;
      req_ch.handler_tag <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty-queue corners
      send_cmd(tepq_pkg::ACT_POP);       // pop on empty
      send_cmd(tepq_pkg::ACT_CLEAR);     // clear on empty
      send_cmd(ACT_SPARE);               // unused code on empty

      // --- directed: extremes and ties
      send_word(tepq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      send_word(tepq_pkg::ACT_INSERT, 32'h0000_0000, 16'h0000, 8'h00);
      send_word(tepq_pkg::ACT_INSERT, 32'h0000_0005, 16'h1111, 8'h11);
      // tie, must leave second
      send_word(tepq_pkg::ACT_INSERT, 32'h0000_0005, 16'h2222, 8'h22);
      // tie, must leave third
      send_word(tepq_pkg::ACT_INSERT, 32'h0000_0005, 16'h3333, 8'h33);
      // tie at max key
      send_word(tepq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 8'h55);
      send_cmd(ACT_SPARE);               // no-op with entries held
      repeat (7) send_cmd(tepq_pkg::ACT_POP);  // drain in order, last one hits empty

      // --- directed: clear with entries held, then confirm empty
      send_word(tepq_pkg::ACT_INSERT, 32'h8000_0000, 16'h5A5A, 8'hA5);
      send_word(tepq_pkg::ACT_INSERT, 32'h7FFF_FFFF, 16'hA5A5, 8'h5A);
      send_cmd(tepq_pkg::ACT_CLEAR);
      send_cmd(tepq_pkg::ACT_POP);
      wait_drained();
      directed_words = sent;

      // --- random phases: mixed traffic, fill-to-full, drains, clears
      while (sent < directed_words + RANDOM_WORDS) begin
         no_idle <= ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 7))
            0, 1, 2: repeat ($urandom_range(20, 60)) send_mixed(55);
            3: begin
               // push past the top so inserts get dropped
               repeat (QUEUE_DEPTH + $urandom_range(1, 4)) send_insert();
               repeat ($urandom_range(0, 3)) send_cmd(ACT_SPARE);
            end
            4: repeat ($urandom_range(20, QUEUE_DEPTH + 4)) send_cmd(tepq_pkg::ACT_POP);
            5: begin
               send_cmd(tepq_pkg::ACT_CLEAR);
               repeat ($urandom_range(5, 30)) send_mixed(65);
            end
            6: repeat ($urandom_range(20, 60)) send_mixed(40);
            default: begin
               // full fill then a full drain, all with tied-heavy keys
               repeat (QUEUE_DEPTH) send_insert();
               repeat (QUEUE_DEPTH + 1) send_cmd(tepq_pkg::ACT_POP);
            end
         endcase
         if ($urandom_range(0, 4) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request words and %0d responses: %0d events popped,",
               sent, checked, popped);
      $display("  %0d pops on empty, %0d inserts dropped when full, peak fill %0d of %0d.",
               empty_hits, full_hits, peak_fill, QUEUE_DEPTH);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> timed_event_priority_queue_core.f
hw/rtl/tepq_pkg.sv
hw/rtl/tepq_if.sv
hw/rtl/tepq_cell.sv
hw/rtl/timed_event_priority_queue_core.sv
hw/rtl/tepq_checker.sv
bench/tepq_checker.sv
bench/timed_event_priority_queue_core_tb.sv
